// ===== hdl/direct_mapped_poison_cache_assert.svh =====
// Assertion macros shared by the cache modules.
`ifndef DIRECT_MAPPED_POISON_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_POISON_CACHE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DMPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dmpc_pkg.sv =====
// Types, geometry constants and command encoding for the poison cache.
`timescale 1ns / 1ps
package dmpc_pkg;

  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 64;
  localparam int ADDR_BITS   = 48;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int TAG_W = ADDR_BITS - OFF_W - IDX_W;

  // Power of two: pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_POISON = 2'd2,
    OP_INVAL  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] address;
    logic [63:0] write_data;
    logic [3:0]  access_bytes;
    logic        write_poisoned;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_data;
    logic        read_poisoned;
    logic        evicted;
  } rsp_t;

  // Classified command, as held in the queue.
  typedef struct packed {
    op_e              op;
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic [63:0]      wdata;
    logic [3:0]       nbytes;
    logic             wpois;
  } cmd_t;

  typedef logic [BLOCK_BYTES-1:0][7:0] row_t;

endpackage

// ===== hdl/direct_mapped_poison_cache.sv =====
// Top level of the direct-mapped cache with per-block poison tracking.
// Path: queue, then pop with array read, then execute into the result register.
// Issue: the back end pops no new word until the last one has executed; the
//   registered tag/data array read is followed by the write-back in execute.
// Reset: valid, poison and row-written bits clear at once; unwritten rows
//   read as zero tag and zero data, so no clearing pass is needed.
`timescale 1ns / 1ps
module direct_mapped_poison_cache import dmpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_word_o
);

  // Front to queue: classified command word.
  logic push;
  logic push_ready;
  cmd_t push_word;

  // Queue to back end.
  logic pop;
  logic pop_valid;
  cmd_t pop_word;

  // Front: splits the address into offset/index/tag, clamps the byte count.
  dmpc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_o       (push),
    .push_word_o  (push_word),
    .push_ready_i (push_ready)
  );

  // Two-entry queue decouples input acceptance from execution stalls.
  dmpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_word_i  (push_word),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_word_o   (pop_word)
  );

  // Back: array read, hit/evict logic, write-back and the result register.
  dmpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_word_i  (pop_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hdl/dmpc_queue.sv =====
// Short command queue between the front and back of the cache.
`timescale 1ns / 1ps
module dmpc_queue import dmpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_word_i,
  output logic push_ready_o,
  input  logic pop_i,
  output logic pop_valid_o,
  output cmd_t pop_word_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_word_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_word_i;
    end
  end

  `include "direct_mapped_poison_cache_assert.svh"

  `DMPC_ASSERT_IMP(a_q_no_overfill, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `DMPC_ASSERT_IMP(a_q_no_underrun, pop_i, cnt_q != '0, "pop from empty queue")
  `DMPC_ASSERT_NXT(a_q_grow, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count not bumped")

endmodule

// ===== hdl/dmpc_front.sv =====
// Front end: takes request words and classifies them into queue commands.
`timescale 1ns / 1ps
module dmpc_front import dmpc_pkg::*; (
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_word_i,
  output logic push_o,
  output cmd_t push_word_o,
  input  logic push_ready_i
);

  logic [IDX_W-1:0] idx_raw;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i;
  assign idx_raw    = in_word_i.address[OFF_W +: IDX_W];

  always_comb begin
    push_word_o.op    = op_e'(in_word_i.req_type);
    push_word_o.off   = in_word_i.address[OFF_W-1:0];
    push_word_o.tag   = in_word_i.address[ADDR_BITS-1 -: TAG_W];
    push_word_o.wdata = in_word_i.write_data;
    push_word_o.wpois = in_word_i.write_poisoned;
    // Non power-of-two block count folds high indexes back.
    if ({1'b0, idx_raw} >= (IDX_W+1)'(NUM_BLOCKS)) begin
      push_word_o.idx = idx_raw - IDX_W'(NUM_BLOCKS);
    end else begin
      push_word_o.idx = idx_raw;
    end
    // Anything over eight bytes moves eight.
    if (in_word_i.access_bytes > 4'd8) begin
      push_word_o.nbytes = 4'd8;
    end else begin
      push_word_o.nbytes = in_word_i.access_bytes;
    end
  end

endmodule

// ===== hdl/dmpc_back.sv =====
// Back end: tag/data arrays, valid and poison bits, execution and result register.
`timescale 1ns / 1ps
module dmpc_back import dmpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pop_valid_i,
  input  cmd_t pop_word_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_word_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_q, state_d;
  cmd_t                  cmd_q;
  logic [TAG_W-1:0]      tag_mem [NUM_BLOCKS];
  row_t                  data_mem [NUM_BLOCKS];
  logic [TAG_W-1:0]      tag_rd_q;
  row_t                  row_rd_q;
  logic [NUM_BLOCKS-1:0] valid_q, poison_q, row_init_q;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_word_q, rsp_d;

  logic             fire;
  logic             blk_valid, tag_eq;
  logic [TAG_W-1:0] old_tag;
  row_t             old_row, new_row;
  logic [63:0]      rd_bytes, wr_echo;

  assign pop_o       = (state_q == ST_IDLE) && pop_valid_i;
  assign fire        = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = pop_o ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = fire ? ST_IDLE : ST_EXEC;
      default: state_d = ST_IDLE;
    endcase
  end

  // Rows never written read as zero, tag included.
  always_comb begin
    logic [OFF_W:0] pos;
    logic [OFF_W:0] rel;
    old_tag   = row_init_q[cmd_q.idx] ? tag_rd_q : '0;
    old_row   = row_init_q[cmd_q.idx] ? row_rd_q : '0;
    blk_valid = valid_q[cmd_q.idx];
    tag_eq    = (old_tag == cmd_q.tag);
    rd_bytes  = '0;
    wr_echo   = '0;
    for (int i = 0; i < 8; i++) begin
      pos = {1'b0, cmd_q.off} + (OFF_W+1)'(i);
      if ((4'(i) < cmd_q.nbytes) && (pos < (OFF_W+1)'(BLOCK_BYTES))) begin
        rd_bytes[8*i +: 8] = old_row[pos[OFF_W-1:0]];
        wr_echo[8*i +: 8]  = cmd_q.wdata[8*i +: 8];
      end
    end
    new_row = old_row;
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      rel = (OFF_W+1)'(j) - {1'b0, cmd_q.off};
      if (((OFF_W+1)'(j) >= {1'b0, cmd_q.off}) && (rel < (OFF_W+1)'(cmd_q.nbytes))) begin
        new_row[j] = cmd_q.wdata[{rel[2:0], 3'b000} +: 8];
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    unique case (cmd_q.op)
      OP_READ: begin
        if (blk_valid && tag_eq) begin
          rsp_d.hit           = 1'b1;
          rsp_d.read_data     = rd_bytes;
          rsp_d.read_poisoned = poison_q[cmd_q.idx];
        end
      end
      OP_WRITE: begin
        rsp_d.hit       = 1'b1;
        rsp_d.read_data = wr_echo;
        rsp_d.evicted   = blk_valid && !tag_eq;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      poison_q    <= '0;
      row_init_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        unique case (cmd_q.op)
          OP_WRITE: begin
            valid_q[cmd_q.idx]    <= 1'b1;
            poison_q[cmd_q.idx]   <= cmd_q.wpois;
            row_init_q[cmd_q.idx] <= 1'b1;
          end
          OP_POISON: begin
            if (tag_eq) begin
              poison_q[cmd_q.idx] <= 1'b1;
            end
          end
          OP_INVAL: begin
            valid_q  <= '0;
            poison_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q    <= pop_word_i;
      tag_rd_q <= tag_mem[pop_word_i.idx];
      row_rd_q <= data_mem[pop_word_i.idx];
    end
    if (fire && (cmd_q.op == OP_WRITE)) begin
      tag_mem[cmd_q.idx]  <= cmd_q.tag;
      data_mem[cmd_q.idx] <= new_row;
    end
    if (fire) begin
      out_word_q <= rsp_d;
    end
  end

  `include "direct_mapped_poison_cache_assert.svh"

  `DMPC_ASSERT_NXT(a_bk_issue, pop_o, state_q == ST_EXEC, "issue did not reach execute")
  `DMPC_ASSERT_NXT(a_bk_flush, fire && (cmd_q.op == OP_INVAL), (valid_q == '0) && (poison_q == '0), "invalidate left bits set")
  `DMPC_ASSERT_NXT(a_bk_alloc, fire && (cmd_q.op == OP_WRITE), valid_q[$past(cmd_q.idx)] && row_init_q[$past(cmd_q.idx)], "write did not allocate")
  `DMPC_ASSERT_IMP(a_bk_pois_hit, out_valid_q && out_word_q.read_poisoned, out_word_q.hit, "poison flag without hit")

endmodule

// ===== tb/direct_mapped_poison_cache_tb.sv =====
// Self-checking testbench for the direct-mapped poison cache: directed table plus random traffic.
`timescale 1ns / 1ps
module direct_mapped_poison_cache_tb;
  import dmpc_pkg::*;

  // Cycles with no word moving on either side before the run is called hung.
  localparam int IDLE_LIMIT = 2000;
  // Receiver hold-off, long enough to fill the queue and pipeline behind it.
  localparam int LONG_HOLD  = 150;
  // Extra wait after the last response has come back.
  localparam int DRAIN_CYC  = 10;
  localparam int N_DIR      = 22;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  req_t in_word_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_word_o;

  direct_mapped_poison_cache u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Cache shadow: what the block should hold after every accepted word.
  // ---------------------------------------------------------------------
  bit [TAG_W-1:0] tag_mem  [NUM_BLOCKS];
  bit             vld_bits [NUM_BLOCKS];
  bit             psn_bits [NUM_BLOCKS];
  bit [7:0]       byte_mem [NUM_BLOCKS*BLOCK_BYTES];

  rsp_t pending_rsp [$];   // responses owed by the block, oldest first

  int  n_err      = 0;
  int  n_sent     = 0;
  int  n_rcvd     = 0;
  int  n_hit      = 0;
  int  n_psn_rd   = 0;
  int  n_evict    = 0;
  bit  quiet      = 1'b0;  // no idling on either side while set
  bit  hold_req   = 1'b0;  // asks the receiver for one long hold-off

  bit [TAG_W-1:0] tag_pool [4];
  bit [IDX_W-1:0] hot_idx  [4];

  // Apply one request to the shadow and return the response it must produce.
  // Bytes past the block end are neither stored nor returned; a length
  // above 8 is clamped to 8, a length of 0 moves nothing.
  function automatic rsp_t cache_access(req_t w);
    rsp_t             r;
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tg;
    int               n;
    int               pos;
    int               i;
    r   = '0;
    off = w.address[OFF_W-1:0];
    idx = w.address[OFF_W +: IDX_W];
    tg  = w.address[OFF_W+IDX_W +: TAG_W];
    n   = (w.access_bytes > 4'd8) ? 8 : int'(w.access_bytes);
    case (op_e'(w.req_type))
      OP_READ: begin
        if (vld_bits[idx] && tag_mem[idx] == tg) begin
          r.hit           = 1'b1;
          r.read_poisoned = psn_bits[idx];
          for (i = 0; i < n; i++) begin
            pos = int'(off) + i;
            if (pos < BLOCK_BYTES)
              r.read_data[8*i +: 8] = byte_mem[int'(idx)*BLOCK_BYTES + pos];
          end
        end
      end
      OP_WRITE: begin
        r.evicted     = vld_bits[idx] && tag_mem[idx] != tg;
        tag_mem[idx]  = tg;
        vld_bits[idx] = 1'b1;
        psn_bits[idx] = w.write_poisoned;
        r.hit         = 1'b1;
        for (i = 0; i < n; i++) begin
          pos = int'(off) + i;
          if (pos < BLOCK_BYTES) begin
            byte_mem[int'(idx)*BLOCK_BYTES + pos] = w.write_data[8*i +: 8];
            r.read_data[8*i +: 8] = w.write_data[8*i +: 8];
          end
        end
      end
      OP_POISON: begin
        // Tag match alone is enough, valid or not.
        if (tag_mem[idx] == tg) psn_bits[idx] = 1'b1;
      end
      default: begin
        foreach (vld_bits[j]) begin
          vld_bits[j] = 1'b0;
          psn_bits[j] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Mostly zero, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random request aimed at a handful of hot blocks and tags so that reads
  // hit, writes evict and poisons land; the rest spreads over the full space.
  function automatic req_t rand_word();
    req_t             w;
    int               r;
    logic [63:0]      t64;
    logic [TAG_W-1:0] tg;
    logic [IDX_W-1:0] ix;
    logic [OFF_W-1:0] of;
    r = $urandom_range(0, 99);
    if (r < 45)      w.req_type = OP_READ;
    else if (r < 85) w.req_type = OP_WRITE;
    else if (r < 98) w.req_type = OP_POISON;
    else             w.req_type = OP_INVAL;
    t64 = rnd64();
    tg  = ($urandom_range(0, 4) == 0) ? t64[TAG_W-1:0] : tag_pool[$urandom_range(0, 3)];
    ix  = ($urandom_range(0, 9) < 7) ? hot_idx[$urandom_range(0, 3)] : IDX_W'($urandom);
    of  = ($urandom_range(0, 3) == 0) ?
          OFF_W'($urandom_range(BLOCK_BYTES-8, BLOCK_BYTES-1)) : OFF_W'($urandom);
    w.address    = {tg, ix, of};
    w.write_data = rnd64();
    r = $urandom_range(0, 9);
    if (r == 0)      w.access_bytes = 4'd0;
    else if (r == 1) w.access_bytes = 4'($urandom_range(9, 15));
    else             w.access_bytes = 4'($urandom_range(1, 8));
    w.write_poisoned = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Offer one word and hold it until taken; the response owed is queued at
  // the accepting edge, either the one typed in the table or the shadow's.
  task automatic send_word(req_t w, bit typed, rsp_t typed_rsp);
    rsp_t pred;
    int   gap;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pred = cache_access(w);
    pending_rsp.push_back(typed ? typed_rsp : pred);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_rsp(rsp_t got);
    rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("response with nothing outstanding: %p", got);
      n_err++;
      return;
    end
    want = pending_rsp.pop_front();
    n_rcvd++;
    if (got.hit !== want.hit) begin
      $error("hit: expected %0b, got %0b", want.hit, got.hit);
      n_err++;
    end
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %h, got %h", want.read_data, got.read_data);
      n_err++;
    end
    if (got.read_poisoned !== want.read_poisoned) begin
      $error("read_poisoned: expected %0b, got %0b", want.read_poisoned, got.read_poisoned);
      n_err++;
    end
    if (got.evicted !== want.evicted) begin
      $error("evicted: expected %0b, got %0b", want.evicted, got.evicted);
      n_err++;
    end
    if (want.hit)           n_hit++;
    if (want.read_poisoned) n_psn_rd++;
    if (want.evicted)       n_evict++;
  endtask

  // ---------------------------------------------------------------------
  // Receive side: takes responses, stalls at random, and honors one long
  // hold-off when asked, counting it here so the sender keeps pushing.
  // ---------------------------------------------------------------------
  initial begin : rsp_side
    int stall_left;
    int hold_left;
    int g;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && out_ready_i) check_rsp(out_word_o);
        if (hold_left > 0) begin
          hold_left--;
          out_ready_i <= 1'b0;
        end else if (hold_req) begin
          hold_req  = 1'b0;
          hold_left = LONG_HOLD - 1;
          out_ready_i <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          g = pick_gap();
          if (g > 0) begin
            stall_left = g - 1;
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      end
    end
  end

  // Hang detector: counts edges where no word moves on either side.
  initial begin : watchdog
    int idle_cyc;
    idle_cyc = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a word moving", IDLE_LIMIT);
        $display("FAIL direct_mapped_poison_cache");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed table. Rows flagged typed carry the response written out by
  // hand; the others take the shadow's answer.
  // ---------------------------------------------------------------------
  typedef struct {
    op_e         op;
    logic [47:0] addr;
    logic [63:0] data;
    logic [3:0]  nb;
    logic        wp;
    bit          typed;
    logic        hit;
    logic [63:0] rdata;
    logic        rpois;
    logic        ev;
  } stim_row_t;

  stim_row_t dir_tab [N_DIR] = '{
    // read miss straight out of reset
    '{OP_READ,   48'h0,              64'h0,                  4'd8,  1'b0, 1, 0, 64'h0, 0, 0},
    // poison on an invalid block whose reset tag matches
    '{OP_POISON, 48'h0,              64'h0,                  4'd8,  1'b0, 1, 0, 64'h0, 0, 0},
    '{OP_READ,   48'h0,              64'h0,                  4'd8,  1'b0, 1, 0, 64'h0, 0, 0},
    '{OP_WRITE,  48'h0,              64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 1, 1,
      64'h0123_4567_89AB_CDEF, 0, 0},
    '{OP_READ,   48'h0,              64'h0,                  4'd8,  1'b0, 0, 0, 64'h0, 0, 0},
    '{OP_POISON, 48'h10,             64'h0,                  4'd1,  1'b0, 1, 0, 64'h0, 0, 0},
    // read hit on a poisoned block
    '{OP_READ,   48'h4,              64'h0,                  4'd4,  1'b0, 0, 0, 64'h0, 0, 0},
    // all-ones write at the last byte: only one byte fits in the block
    '{OP_WRITE,  48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1, 1, 64'hFF, 0, 0},
    // oversized read that also runs off the block end
    '{OP_READ,   48'hFFFF_FFFF_FFFF, 64'h0,                  4'd15, 1'b0, 0, 0, 64'h0, 0, 0},
    // oversized write, same tag: no eviction
    '{OP_WRITE,  48'hFFFF_FFFF_FFC0, 64'h8000_0000_0000_0001, 4'd15, 1'b0, 1, 1,
      64'h8000_0000_0000_0001, 0, 0},
    // empty write to a valid block with another tag: evicts, moves nothing
    '{OP_WRITE,  48'h0000_0000_0FC0, 64'hDEAD,               4'd0,  1'b0, 1, 1, 64'h0, 0, 1},
    '{OP_READ,   48'h0000_0000_0FC0, 64'h0,                  4'd8,  1'b0, 0, 0, 64'h0, 0, 0},
    '{OP_WRITE,  48'h1040,           64'hA5A5_A5A5_A5A5_A5A5, 4'd3, 1'b1, 0, 0, 64'h0, 0, 0},
    '{OP_READ,   48'h1040,           64'h0,                  4'd2,  1'b0, 0, 0, 64'h0, 0, 0},
    // tag mismatch on a valid block
    '{OP_READ,   48'h2040,           64'h0,                  4'd8,  1'b0, 0, 0, 64'h0, 0, 0},
    '{OP_POISON, 48'h2040,           64'h0,                  4'd8,  1'b0, 1, 0, 64'h0, 0, 0},
    // flash invalidate with every other field at its top value
    '{OP_INVAL,  48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1, 0, 64'h0, 0, 0},
    '{OP_READ,   48'h0,              64'h0,                  4'd8,  1'b0, 1, 0, 64'h0, 0, 0},
    '{OP_WRITE,  48'h0,              64'hFEDC_BA98_7654_3277, 4'd1, 1'b0, 1, 1, 64'h77, 0, 0},
    // empty read hit
    '{OP_READ,   48'h1,              64'h0,                  4'd0,  1'b0, 0, 0, 64'h0, 0, 0},
    '{OP_POISON, 48'h3F,             64'h0,                  4'd8,  1'b0, 1, 0, 64'h0, 0, 0},
    '{OP_READ,   48'h3F,             64'h0,                  4'd8,  1'b0, 0, 0, 64'h0, 0, 0}
  };

  initial begin : main_seq
    req_t w;
    rsp_t r;
    int   k;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_W'(36'h5_A5A5_A5A5);
    tag_pool[3] = TAG_W'(rnd64());
    hot_idx[0]  = '0;
    hot_idx[1]  = IDX_W'(1);
    hot_idx[2]  = IDX_W'(2);
    hot_idx[3]  = IDX_W'(NUM_BLOCKS - 1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < N_DIR; k++) begin
      w.req_type       = dir_tab[k].op;
      w.address        = dir_tab[k].addr;
      w.write_data     = dir_tab[k].data;
      w.access_bytes   = dir_tab[k].nb;
      w.write_poisoned = dir_tab[k].wp;
      r.hit            = dir_tab[k].hit;
      r.read_data      = dir_tab[k].rdata;
      r.read_poisoned  = dir_tab[k].rpois;
      r.evicted        = dir_tab[k].ev;
      send_word(w, dir_tab[k].typed, r);
    end
    // Sender stands still until every owed response is back.
    drain_all();

    // Random traffic with idling; partway in the receiver holds off for a
    // long stretch while words keep coming, so the input has to stall.
    for (k = 0; k < 300; k++) begin
      if (k == 100) hold_req = 1'b1;
      send_word(rand_word(), 1'b0, '0);
    end
    drain_all();

    // Back-to-back stretch, no idling on either side.
    quiet = 1'b1;
    for (k = 0; k < 150; k++) send_word(rand_word(), 1'b0, '0);
    quiet = 1'b0;

    for (k = 0; k < 200; k++) send_word(rand_word(), 1'b0, '0);
    drain_all();
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Ran %0d words (directed table, random traffic, long hold-off, back-to-back burst).",
             n_sent);
    $display("Checked %0d responses: %0d hits, %0d poisoned reads, %0d evictions, %0d errors.",
             n_rcvd, n_hit, n_psn_rd, n_evict, n_err);
    if (n_err == 0) begin
      $display("PASS direct_mapped_poison_cache");
    end else begin
      $display("FAIL direct_mapped_poison_cache");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dmpc_pkg.sv
hdl/dmpc_queue.sv
hdl/dmpc_front.sv
hdl/dmpc_back.sv
hdl/direct_mapped_poison_cache.sv
tb/direct_mapped_poison_cache_tb.sv
